>>> rtl/clock_page_replacement_assert.svh
// ----------------------------------------------------------------------------
// clock_page_replacement_assert.svh
// Assertion macros used by the clock page replacement sequencer (clkpr_seq).
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CLKPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLKPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/clkpr_pkg.sv
// ----------------------------------------------------------------------------
// clkpr_pkg
// Types and constants of the clock page replacement block.
// ----------------------------------------------------------------------------
package clkpr_pkg;

  localparam int CFG_W       = 6;
  localparam int FRAME_IDX_W = 5;
  localparam int OUT_PAGE_W  = 20;
  localparam int FAULT_W     = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_SWEEP,
    S_FILL,
    S_DONE
  } state_e;

  // commands from the sequencer to the frame table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_ref;
    logic clr_ref;
  } tbl_cmd_t;

  // status from the frame table
  typedef struct packed {
    logic rd_valid;   // valid bit of the last read frame, registered with data
    logic ref_bit;    // reference bit at the current address
  } tbl_stat_t;

endpackage

>>> rtl/clkpr_table.sv
// ----------------------------------------------------------------------------
// clkpr_table
// Frame table: page memory with registered read, valid and reference flops.
// ----------------------------------------------------------------------------
module clkpr_table #(
  parameter int  MAX_FRAMES = 32,
  parameter int  PAGE_BITS  = 20,
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clkpr_pkg::tbl_cmd_t   cmd_i,
  input  logic [IDX_W-1:0]      addr_i,
  input  logic [PAGE_BITS-1:0]  wr_page_i,
  output logic [PAGE_BITS-1:0]  rd_page_o,
  output clkpr_pkg::tbl_stat_t  stat_o
);
  import clkpr_pkg::*;

  logic [PAGE_BITS-1:0]  frame_page_q [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  rd_page_q;
  logic                  rd_valid_q;
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] ref_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      frame_page_q[addr_i] <= wr_page_i;
    end
    if (cmd_i.rd_en) begin
      rd_page_q <= frame_page_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      ref_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[addr_i];
      end
      if (cmd_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (cmd_i.set_ref) begin
        ref_q[addr_i] <= 1'b1;
      end else if (cmd_i.clr_ref) begin
        ref_q[addr_i] <= 1'b0;
      end
    end
  end

  assign rd_page_o       = rd_page_q;
  assign stat_o.rd_valid = rd_valid_q;
  assign stat_o.ref_bit  = ref_q[addr_i];

endmodule

>>> rtl/clkpr_seq.sv
// ----------------------------------------------------------------------------
// clkpr_seq
// Sequencer: serial lookup through one page comparator, clock hand sweep,
// fill, fault counter and result register.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_assert.svh"

module clkpr_seq #(
  parameter int  MAX_FRAMES = 32,
  parameter int  PAGE_BITS  = 20,
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [clkpr_pkg::CFG_W-1:0]        frames_in_use_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [PAGE_BITS-1:0]               page_number_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic [clkpr_pkg::FRAME_IDX_W-1:0]  frame_index_o,
  output logic                               evicted_valid_o,
  output logic [clkpr_pkg::OUT_PAGE_W-1:0]   evicted_page_o,
  output logic [clkpr_pkg::FAULT_W-1:0]      fault_count_o,
  output clkpr_pkg::tbl_cmd_t                tbl_cmd_o,
  output logic [IDX_W-1:0]                   tbl_addr_o,
  output logic [PAGE_BITS-1:0]               tbl_wr_page_o,
  input  logic [PAGE_BITS-1:0]               tbl_rd_page_i,
  input  clkpr_pkg::tbl_stat_t               tbl_stat_i
);
  import clkpr_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRAMES);

  state_e               state_q, state_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     hand_q, hand_d;
  logic [FAULT_W-1:0]   fault_q, fault_d;
  logic                 res_hit_q, res_hit_d;
  logic [IDX_W-1:0]     res_frame_q, res_frame_d;
  logic                 res_ev_vld_q, res_ev_vld_d;
  logic [PAGE_BITS-1:0] res_ev_page_q, res_ev_page_d;

  logic [CNT_W-1:0]     n_cfg;
  logic [CNT_W:0]       hand_nxt;
  logic [IDX_W-1:0]     hand_adv;
  logic                 hand_in_range;
  logic                 issue;
  logic                 last_cmp;
  logic                 match;

  logic [IDX_W+FRAME_IDX_W-1:0]     frame_ext;
  logic [PAGE_BITS+OUT_PAGE_W-1:0]  page_ext;

  // zero frames act as one, too many as the built count
  always_comb begin
    if (frames_in_use_i == '0) begin
      n_cfg = CNT_W'(1);
    end else if (32'(frames_in_use_i) > MAX_FRAMES) begin
      n_cfg = MaxCnt;
    end else begin
      n_cfg = CNT_W'(frames_in_use_i);
    end
  end

  assign hand_nxt      = (CNT_W+1)'(hand_q) + (CNT_W+1)'(1);
  assign hand_adv      = (hand_nxt >= (CNT_W+1)'(n_q)) ? '0 : hand_nxt[IDX_W-1:0];
  assign hand_in_range = (CNT_W+1)'(hand_q) < (CNT_W+1)'(n_q);
  assign issue         = ptr_q < n_q;
  assign last_cmp      = ((CNT_W+1)'(cmp_idx_q) + (CNT_W+1)'(1)) == (CNT_W+1)'(n_q);
  // the shared comparator: one stored frame per cycle against the page
  assign match         = cmp_vld_q && tbl_stat_i.rd_valid && (tbl_rd_page_i == page_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN: begin
        if (match) begin
          state_d = S_HIT;
        end else if (cmp_vld_q && last_cmp) begin
          state_d = S_SWEEP;
        end
      end
      S_HIT:   state_d = S_DONE;
      S_SWEEP: if (!tbl_stat_i.ref_bit) state_d = S_FILL;
      S_FILL:  state_d = S_DONE;
      S_DONE:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and table commands
  always_comb begin
    tbl_cmd_o   = '0;
    tbl_addr_o  = hand_q;
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_DONE);
    unique case (state_q)
      S_SCAN: begin
        tbl_cmd_o.rd_en = issue;
        tbl_addr_o      = ptr_q[IDX_W-1:0];
      end
      S_HIT: begin
        tbl_cmd_o.set_ref = 1'b1;
        tbl_addr_o        = cmp_idx_q;
      end
      S_SWEEP: begin
        // second chance: clear a set bit and move on, else read the victim
        tbl_cmd_o.clr_ref = tbl_stat_i.ref_bit;
        tbl_cmd_o.rd_en   = !tbl_stat_i.ref_bit;
      end
      S_FILL: begin
        tbl_cmd_o.wr_en   = 1'b1;
        tbl_cmd_o.set_ref = 1'b1;
      end
      default: ;
    endcase
  end

  assign tbl_wr_page_o = page_q;

  // datapath registers
  always_comb begin
    page_d        = page_q;
    n_d           = n_q;
    ptr_d         = ptr_q;
    cmp_idx_d     = cmp_idx_q;
    cmp_vld_d     = 1'b0;
    hand_d        = hand_q;
    fault_d       = fault_q;
    res_hit_d     = res_hit_q;
    res_frame_d   = res_frame_q;
    res_ev_vld_d  = res_ev_vld_q;
    res_ev_page_d = res_ev_page_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          page_d = page_number_i;
          n_d    = n_cfg;
          ptr_d  = '0;
        end
      end
      S_SCAN: begin
        cmp_vld_d = issue;
        // a match freezes the index so the hit state sees the matching frame
        if (issue && !match) begin
          ptr_d     = ptr_q + CNT_W'(1);
          cmp_idx_d = ptr_q[IDX_W-1:0];
        end
        // miss: hand left beyond a lowered count restarts at frame zero
        if (!match && cmp_vld_q && last_cmp && !hand_in_range) begin
          hand_d = '0;
        end
      end
      S_HIT: begin
        res_hit_d     = 1'b1;
        res_frame_d   = cmp_idx_q;
        res_ev_vld_d  = 1'b0;
        res_ev_page_d = '0;
      end
      S_SWEEP: begin
        if (tbl_stat_i.ref_bit) begin
          hand_d = hand_adv;
        end
      end
      S_FILL: begin
        res_hit_d     = 1'b0;
        res_frame_d   = hand_q;
        res_ev_vld_d  = tbl_stat_i.rd_valid;
        res_ev_page_d = tbl_stat_i.rd_valid ? tbl_rd_page_i : '0;
        hand_d        = hand_adv;
        if (fault_q != '1) begin
          fault_d = fault_q + FAULT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
      hand_q    <= '0;
      fault_q   <= '0;
      n_q       <= '0;
      ptr_q     <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      hand_q    <= hand_d;
      fault_q   <= fault_d;
      n_q       <= n_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q        <= page_d;
    cmp_idx_q     <= cmp_idx_d;
    res_hit_q     <= res_hit_d;
    res_frame_q   <= res_frame_d;
    res_ev_vld_q  <= res_ev_vld_d;
    res_ev_page_q <= res_ev_page_d;
  end

  assign frame_ext       = {{FRAME_IDX_W{1'b0}}, res_frame_q};
  assign page_ext        = {{OUT_PAGE_W{1'b0}}, res_ev_page_q};
  assign hit_o           = res_hit_q;
  assign frame_index_o   = frame_ext[FRAME_IDX_W-1:0];
  assign evicted_valid_o = res_ev_vld_q;
  assign evicted_page_o  = page_ext[OUT_PAGE_W-1:0];
  assign fault_count_o   = fault_q;

  `CLKPR_ASSERT_IMP(a_idle_no_result, !in_stall_o, !out_valid_o, "result while idle")
  `CLKPR_ASSERT_IMP(a_hit_no_evict, out_valid_o && hit_o, !evicted_valid_o, "evict on hit")
  `CLKPR_ASSERT_IMP(a_sweep_hand, state_q == S_SWEEP, hand_in_range, "hand out of range")
  `CLKPR_ASSERT_NXT(a_fault_only_fill, state_q != S_FILL, $stable(fault_q), "fault count moved")
  `CLKPR_ASSERT_NXT(a_fault_mono, 1'b1, fault_q >= $past(fault_q), "fault count fell")

endmodule

>>> rtl/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement unit, one page reference per item.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with page_number_i. An item is taken
// when in_valid_i is high and in_stall_o is low. One item is in flight at a
// time; in_stall_o stays high from acceptance until its result is taken.
// Output channel: out_valid_o / out_stall_i with hit_o, frame_index_o,
// evicted_valid_o, evicted_page_o and fault_count_o. A stalled result holds.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_data_i = frames_in_use
// (N, clamped to 1..MAX_FRAMES). Write only while idle.
// From acceptance to out_valid_o, a hit costs the serial lookup through one
// comparator up to the matching frame; a miss costs the full lookup plus the
// hand sweep, one frame per cycle, clearing set reference bits up to the victim.
// The next item is taken the cycle after the result leaves.
// Reset clears valid and reference flops at once; no clearing pass. Frames
// start empty, the hand at zero, the fault count at zero, N at 4.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int MAX_FRAMES = 32,
  parameter int PAGE_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [clkpr_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [PAGE_BITS-1:0]               page_number_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic [clkpr_pkg::FRAME_IDX_W-1:0]  frame_index_o,
  output logic                               evicted_valid_o,
  output logic [clkpr_pkg::OUT_PAGE_W-1:0]   evicted_page_o,
  output logic [clkpr_pkg::FAULT_W-1:0]      fault_count_o
);
  import clkpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [CFG_W-1:0]     frames_in_use_q;
  tbl_cmd_t             tbl_cmd;
  tbl_stat_t            tbl_stat;
  logic [IDX_W-1:0]     tbl_addr;
  logic [PAGE_BITS-1:0] tbl_wr_page;
  logic [PAGE_BITS-1:0] tbl_rd_page;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_in_use_q <= cfg_data_i;
    end
  end

  clkpr_seq #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o),
    .tbl_cmd_o       (tbl_cmd),
    .tbl_addr_o      (tbl_addr),
    .tbl_wr_page_o   (tbl_wr_page),
    .tbl_rd_page_i   (tbl_rd_page),
    .tbl_stat_i      (tbl_stat)
  );

  clkpr_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .addr_i    (tbl_addr),
    .wr_page_i (tbl_wr_page),
    .rd_page_o (tbl_rd_page),
    .stat_o    (tbl_stat)
  );

endmodule

>>> bench/clock_page_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement_tb
// Self-checking bench for the clock (second chance) page replacement unit.
// A behavioral copy of the frame table predicts hit/fault, frame, eviction
// and fault count for every accepted page reference; a monitor compares each
// result against the oldest prediction. Directed cases cover empty frames,
// out-of-range frame counts and a lowered count. Random phases run under
// varying sender/receiver idling and frame counts, plus one long output stall.
// ----------------------------------------------------------------------------
module clock_page_replacement_tb;
  import clkpr_pkg::*;

  localparam int MAX_FRAMES      = 32;
  localparam int PAGE_BITS       = 20;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 2 * MAX_FRAMES + 16;
  localparam int MAX_GAP         = 40;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [OUT_PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0]     faults;
  } page_outcome_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [PAGE_BITS-1:0]   page_number_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic                   hit_o;
  logic [FRAME_IDX_W-1:0] frame_index_o;
  logic                   evicted_valid_o;
  logic [OUT_PAGE_W-1:0]  evicted_page_o;
  logic [FAULT_W-1:0]     fault_count_o;

  // predictor state
  logic [PAGE_BITS-1:0] pg_tbl [MAX_FRAMES];
  logic                 pg_present [MAX_FRAMES];
  logic                 pg_referenced [MAX_FRAMES];
  int                   hand_pos;
  logic [FAULT_W-1:0]   fault_tally;
  logic [CFG_W-1:0]     frame_count_reg;

  page_outcome_t pending_outcomes[$];

  int sender_idle_pct  = 0;
  int recv_stall_pct   = 0;
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int hold_left         = 0;
  int quiet_cycles      = 0;
  int mismatches        = 0;
  int refs_sent         = 0;
  int hits_seen         = 0;
  int faults_seen       = 0;
  int evictions_seen    = 0;
  int count_writes      = 0;

  clock_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int effective_frames();
    int n;
    n = frame_count_reg;
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  // second-chance replacement on the copy of the frame table
  function automatic page_outcome_t predict_reference(input logic [PAGE_BITS-1:0] pg);
    page_outcome_t res;
    int            n;
    int            slot;
    bit            found;
    n     = effective_frames();
    slot  = 0;
    found = 1'b0;
    res   = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && pg_present[i] && pg_tbl[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      pg_referenced[slot] = 1'b1;
    end else begin
      if (hand_pos >= n) hand_pos = 0;
      while (pg_referenced[hand_pos]) begin
        pg_referenced[hand_pos] = 1'b0;
        hand_pos = (hand_pos + 1 >= n) ? 0 : hand_pos + 1;
      end
      slot = hand_pos;
      if (pg_present[slot]) begin
        res.ev_valid = 1'b1;
        res.ev_page  = pg_tbl[slot];
      end
      pg_tbl[slot]        = pg;
      pg_present[slot]    = 1'b1;
      pg_referenced[slot] = 1'b1;
      hand_pos = (hand_pos + 1 >= n) ? 0 : hand_pos + 1;
      if (fault_tally != '1) fault_tally++;
    end
    res.hit    = found;
    res.frame  = FRAME_IDX_W'(slot);
    res.faults = fault_tally;
    return res;
  endfunction

  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    int            gap;
    page_outcome_t res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = predict_reference(pg);
    pending_outcomes.push_back(res);
    refs_sent++;
    if (res.hit) hits_seen++;
    else faults_seen++;
    if (res.ev_valid) evictions_seen++;
  endtask

  // stop offering and wait until every outstanding result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
  endtask

  task automatic set_frame_count(input logic [CFG_W-1:0] cnt);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i     <= 1'b0;
    frame_count_reg  = cnt;
    count_writes++;
  endtask

  // result monitor and output stall driver
  always @(posedge clk_i) begin
    page_outcome_t got;
    page_outcome_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {hit_o, frame_index_o, evicted_valid_o, evicted_page_o, fault_count_o};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected result hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                   $time, got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit || got.frame !== want.frame ||
            got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
            got.faults !== want.faults) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: exp hit=%0b frame=%0d ev=%0b/%h faults=%0d, got hit=%0b frame=%0d ev=%0b/%h faults=%0d",
                     $time, want.hit, want.frame, want.ev_valid, want.ev_page, want.faults,
                     got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
        end
      end
    end
    if (hold_off_served != hold_off_requests) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 quiet_cycles, pending_outcomes.size());
        $display("clock_page_replacement_tb: FAIL");
        $finish;
      end
    end
  end

  // reset count of four: fill empty frames, hit, then a full sweep
  task automatic test_empty_frames();
    send_page(20'h00000);
    send_page(20'hFFFFF);
    send_page(20'h00000);
    send_page(20'h00005);
    send_page(20'h00006);
    send_page(20'h00008);
    send_page(20'hA5A5A);
    send_page(20'h55555);
    send_page(20'hFFFFF);
  endtask

  // zero acts as one frame, values above the table size clamp
  task automatic test_count_limits();
    set_frame_count(6'd0);
    send_page(20'h00010);
    send_page(20'h00010);
    send_page(20'h00011);
    set_frame_count(6'd63);
    send_page(20'h00012);
    send_page(20'h00013);
    set_frame_count(6'd33);
    send_page(20'h00012);
  endtask

  // lowering the count puts the hand out of range; hidden frames come back
  task automatic test_count_lowered();
    set_frame_count(6'd32);
    for (int p = 'h20; p < 'h26; p++) send_page(PAGE_BITS'(p));
    set_frame_count(6'd2);
    send_page(20'h00026);
    send_page(20'h00021);   // hidden at two frames, lands in a low frame
    set_frame_count(6'd32);
    send_page(20'h00021);   // resident twice: lowest frame wins
    send_page(20'h00024);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int refs);
    logic [PAGE_BITS-1:0] base;
    logic [CFG_W-1:0]     cnt;
    int                   n;
    int                   sel;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int blk = 0; blk < 3; blk++) begin
      sel = $urandom_range(99);
      if (sel < 10)      cnt = 6'd1;
      else if (sel < 20) cnt = 6'd32;
      else if (sel < 25) cnt = 6'd0;
      else if (sel < 32) cnt = CFG_W'($urandom_range(63, 33));
      else               cnt = CFG_W'($urandom_range(31, 2));
      set_frame_count(cnt);
      n    = effective_frames();
      base = PAGE_BITS'($urandom);
      for (int k = 0; k < refs / 3; k++) begin
        if ($urandom_range(99) < 85)
          send_page(base + PAGE_BITS'($urandom_range(n + n / 2 + 2)));
        else
          send_page(PAGE_BITS'($urandom));
      end
    end
  endtask

  // long output stall while references keep coming
  task automatic test_output_backpressure();
    logic [PAGE_BITS-1:0] base;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    set_frame_count(6'd8);
    base = PAGE_BITS'($urandom);
    hold_off_requests++;
    for (int k = 0; k < 40; k++) send_page(base + PAGE_BITS'($urandom_range(11)));
  endtask

  initial begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      pg_tbl[i]        = '0;
      pg_present[i]    = 1'b0;
      pg_referenced[i] = 1'b0;
    end
    hand_pos        = 0;
    fault_tally     = '0;
    frame_count_reg = CFG_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frames();
    test_count_limits();
    test_count_lowered();
    test_random_phase(0, 0, 345);
    test_random_phase(63, 0, 345);
    test_random_phase(0, 63, 345);
    test_random_phase(19, 19, 345);
    test_output_backpressure();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d page references: %0d hits, %0d faults, %0d evictions",
             refs_sent, hits_seen, faults_seen, evictions_seen);
    $display("%0d frame-count writes across idle/stall mixes; %0d mismatches",
             count_writes, mismatches);
    if (mismatches == 0) begin
      $display("clock_page_replacement_tb: PASS");
    end else begin
      $display("clock_page_replacement_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> clock_page_replacement.f
+incdir+rtl
rtl/clkpr_pkg.sv
rtl/clkpr_table.sv
rtl/clkpr_seq.sv
rtl/clock_page_replacement.sv
bench/clock_page_replacement_tb.sv
